// ===== hw/rtl/lphtu_pkg.sv =====
// Shared types and constants for the linear-probe hash table unit.
// No dependencies; used by lphtu_ctrl, lphtu_dp and the top level.
`default_nettype none

package lphtu_pkg;

	// Slot count; a power of two, so the home slot is the low key bits
	// and the probe index wraps on its own.
	localparam int TABLE_SIZE = 32;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

	localparam int FUNC_W = 2;
	localparam int KEY_W  = 31;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int SLOT_W = 5;

	typedef enum logic [FUNC_W-1:0] {
		FN_SEARCH = 2'd0,
		FN_INSERT = 2'd1,
		FN_DELETE = 2'd2
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MK_EMPTY = 2'd0,
		MK_USED  = 2'd1,
		MK_TOMB  = 2'd2
	} mark_t;

	typedef enum logic [1:0] {
		RES_HIT   = 2'd0,
		RES_CLAIM = 2'd1,
		RES_MISS  = 2'd2,
		RES_FULL  = 2'd3
	} res_kind_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_PROBE = 2'd1,
		S_RESP  = 2'd2
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic      load;
		logic      issue;
		logic      set_res;
		res_kind_t res_kind;
		logic      wr_claim;
		logic      wr_tomb;
		logic      out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              ev_vld;
		logic              ev_empty;
		logic              ev_used;
		logic              ev_match;
		logic              ev_last;
		logic              can_issue;
		logic              out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lphtu_dp.sv =====
// Datapath of the linear-probe hash table: request registers, slot marks,
// key/value memories, probe counters, result and output registers.
// Depends on lphtu_pkg.
`default_nettype none

module lphtu_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [lphtu_pkg::FUNC_W-1:0]      in_func,
	input  wire logic [lphtu_pkg::KEY_W-1:0]       in_key,
	input  wire logic signed [lphtu_pkg::DATA_W-1:0] in_data,
	input  wire lphtu_pkg::cmd_t                   cmd,
	output lphtu_pkg::sts_t                        sts,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [lphtu_pkg::STAT_W-1:0]           status,
	output logic [lphtu_pkg::SLOT_W-1:0]           slot,
	output logic signed [lphtu_pkg::DATA_W-1:0]    found_data
);

	logic [lphtu_pkg::FUNC_W-1:0]  func_q;
	logic [lphtu_pkg::KEY_W-1:0]   key_q;
	logic [lphtu_pkg::DATA_W-1:0]  data_q;

	logic [lphtu_pkg::IDX_W-1:0]   probe_idx_q;
	logic [lphtu_pkg::CNT_W-1:0]   probe_cnt_q;

	logic                          rd_vld_s1;
	logic                          rd_last_s1;
	logic [lphtu_pkg::IDX_W-1:0]   rd_idx_s1;
	lphtu_pkg::mark_t              rd_mark_s1;
	logic [lphtu_pkg::KEY_W-1:0]   rd_key_s1;
	logic [lphtu_pkg::DATA_W-1:0]  rd_val_s1;

	lphtu_pkg::mark_t              mark_q [lphtu_pkg::TABLE_SIZE];
	logic [lphtu_pkg::KEY_W-1:0]   key_mem [lphtu_pkg::TABLE_SIZE];
	logic [lphtu_pkg::DATA_W-1:0]  val_mem [lphtu_pkg::TABLE_SIZE];

	lphtu_pkg::status_t            res_status_q;
	logic [lphtu_pkg::SLOT_W-1:0]  res_slot_q;
	logic [lphtu_pkg::DATA_W-1:0]  res_data_q;

	logic                          out_valid_q;
	lphtu_pkg::status_t            out_status_q;
	logic [lphtu_pkg::SLOT_W-1:0]  out_slot_q;
	logic [lphtu_pkg::DATA_W-1:0]  out_data_q;

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			key_q  <= in_key;
			data_q <= in_data;
		end
	end

	// Probe address and count; read stage tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_idx_q <= '0;
			probe_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
			rd_idx_s1   <= '0;
		end else if (cmd.load) begin
			probe_idx_q <= in_key[lphtu_pkg::IDX_W-1:0];
			probe_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
		end else if (cmd.issue) begin
			probe_idx_q <= probe_idx_q + 1'b1;
			probe_cnt_q <= probe_cnt_q + 1'b1;
			rd_vld_s1   <= 1'b1;
			rd_idx_s1   <= probe_idx_q;
			rd_last_s1  <= (probe_cnt_q == lphtu_pkg::CNT_W'(lphtu_pkg::TABLE_SIZE - 1));
		end else begin
			rd_vld_s1   <= 1'b0;
		end
	end

	// Slot marks: cleared to empty at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lphtu_pkg::TABLE_SIZE; i++) begin
				mark_q[i] <= lphtu_pkg::MK_EMPTY;
			end
		end else if (cmd.wr_claim) begin
			mark_q[rd_idx_s1] <= lphtu_pkg::MK_USED;
		end else if (cmd.wr_tomb) begin
			mark_q[rd_idx_s1] <= lphtu_pkg::MK_TOMB;
		end
	end

	// Key/value memories, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_claim) begin
			key_mem[rd_idx_s1] <= key_q;
			val_mem[rd_idx_s1] <= data_q;
		end
		if (cmd.issue) begin
			rd_key_s1  <= key_mem[probe_idx_q];
			rd_val_s1  <= val_mem[probe_idx_q];
			rd_mark_s1 <= mark_q[probe_idx_q];
		end
	end

	always_comb begin
		sts.func      = func_q;
		sts.ev_vld    = rd_vld_s1;
		sts.ev_empty  = (rd_mark_s1 == lphtu_pkg::MK_EMPTY);
		sts.ev_used   = (rd_mark_s1 == lphtu_pkg::MK_USED);
		sts.ev_match  = (rd_key_s1 == key_q);
		sts.ev_last   = rd_last_s1;
		sts.can_issue = (probe_cnt_q < lphtu_pkg::CNT_W'(lphtu_pkg::TABLE_SIZE));
		sts.out_free  = !out_valid_q || out_ready;
	end

	// Result hold
	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			unique case (cmd.res_kind)
				lphtu_pkg::RES_HIT: begin
					res_status_q <= lphtu_pkg::ST_OK;
					res_slot_q   <= lphtu_pkg::SLOT_W'(rd_idx_s1);
					res_data_q   <= rd_val_s1;
				end
				lphtu_pkg::RES_CLAIM: begin
					res_status_q <= lphtu_pkg::ST_OK;
					res_slot_q   <= lphtu_pkg::SLOT_W'(rd_idx_s1);
					res_data_q   <= '0;
				end
				lphtu_pkg::RES_MISS: begin
					res_status_q <= lphtu_pkg::ST_MISS;
					res_slot_q   <= '0;
					res_data_q   <= '0;
				end
				lphtu_pkg::RES_FULL: begin
					res_status_q <= lphtu_pkg::ST_FULL;
					res_slot_q   <= '0;
					res_data_q   <= '0;
				end
				default: begin
					res_status_q <= lphtu_pkg::ST_MISS;
					res_slot_q   <= '0;
					res_data_q   <= '0;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_data_q   <= res_data_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign slot       = out_slot_q;
	assign found_data = out_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lphtu_ctrl.sv =====
// Controller state machine of the linear-probe hash table.
// Drives lphtu_dp through cmd_t and watches sts_t; depends on lphtu_pkg.
`default_nettype none

module lphtu_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire lphtu_pkg::sts_t sts,
	output lphtu_pkg::cmd_t      cmd
);

	lphtu_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lphtu_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.issue    = 1'b0;
		cmd.set_res  = 1'b0;
		cmd.res_kind = lphtu_pkg::RES_MISS;
		cmd.wr_claim = 1'b0;
		cmd.wr_tomb  = 1'b0;
		cmd.out_load = 1'b0;

		unique case (state_q)
			lphtu_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = lphtu_pkg::S_PROBE;
				end
			end
			lphtu_pkg::S_PROBE: begin
				cmd.issue = sts.can_issue;
				unique case (lphtu_pkg::func_t'(sts.func))
					lphtu_pkg::FN_SEARCH, lphtu_pkg::FN_DELETE: begin
						if (sts.ev_vld) begin
							priority if (sts.ev_empty) begin
								cmd.set_res  = 1'b1;
								cmd.res_kind = lphtu_pkg::RES_MISS;
								state_d      = lphtu_pkg::S_RESP;
							end else if (sts.ev_used && sts.ev_match) begin
								cmd.set_res  = 1'b1;
								cmd.res_kind = lphtu_pkg::RES_HIT;
								cmd.wr_tomb  = (sts.func == lphtu_pkg::FN_DELETE);
								state_d      = lphtu_pkg::S_RESP;
							end else if (sts.ev_last) begin
								cmd.set_res  = 1'b1;
								cmd.res_kind = lphtu_pkg::RES_MISS;
								state_d      = lphtu_pkg::S_RESP;
							end else begin
								state_d      = lphtu_pkg::S_PROBE;
							end
						end
					end
					lphtu_pkg::FN_INSERT: begin
						if (sts.ev_vld) begin
							priority if (!sts.ev_used) begin
								cmd.set_res  = 1'b1;
								cmd.res_kind = lphtu_pkg::RES_CLAIM;
								cmd.wr_claim = 1'b1;
								state_d      = lphtu_pkg::S_RESP;
							end else if (sts.ev_last) begin
								cmd.set_res  = 1'b1;
								cmd.res_kind = lphtu_pkg::RES_FULL;
								state_d      = lphtu_pkg::S_RESP;
							end else begin
								state_d      = lphtu_pkg::S_PROBE;
							end
						end
					end
					default: begin
						// unused operation: drop it with a miss
						cmd.issue    = 1'b0;
						cmd.set_res  = 1'b1;
						cmd.res_kind = lphtu_pkg::RES_MISS;
						state_d      = lphtu_pkg::S_RESP;
					end
				endcase
			end
			lphtu_pkg::S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = lphtu_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lphtu_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/linear_probe_hash_table_unit.sv =====
// Top level of the linear-probe hash table unit.
// Instantiates lphtu_ctrl and lphtu_dp; depends on lphtu_pkg.
//
// Usage
//   Request channel (in_valid/in_ready, func/key/data): one request is
//   search, insert or delete on a 32-slot open-addressing table. The probe
//   starts at the home slot (low key bits) and walks forward, wrapping.
//   Response channel (out_valid/out_ready, status/slot/found_data): one
//   response per request, in request order.
//   Timing: the unit works on one request at a time. A request is
//   captured, then the probe walk reads one slot per cycle from the
//   key/value memory, whose read is registered, until a slot decides the
//   request or a full lap of 32 slots is done; last, the response is
//   loaded into the output register, and out_valid rises. An unused
//   operation code skips the probe walk.
//   Stall: the response sits in an output register, so a new request is
//   accepted while it waits; if the receiver has still not taken it when
//   the next response is ready, the unit holds that response and accepts
//   nothing until the output register frees up.
//   Reset: arst_n clears every slot to empty at once, and empties the
//   output register; key and value storage is not cleared.
`default_nettype none

module linear_probe_hash_table_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [lphtu_pkg::FUNC_W-1:0]      func,
	input  wire logic [lphtu_pkg::KEY_W-1:0]       key,
	input  wire logic signed [lphtu_pkg::DATA_W-1:0] data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [lphtu_pkg::STAT_W-1:0]           status,
	output logic [lphtu_pkg::SLOT_W-1:0]           slot,
	output logic signed [lphtu_pkg::DATA_W-1:0]    found_data
);

	lphtu_pkg::cmd_t cmd;
	lphtu_pkg::sts_t sts;

	// Sequencing: capture, probe walk, response hand-off
	lphtu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Storage, compare and output register
	lphtu_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_func    (func),
		.in_key     (key),
		.in_data    (data),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot       (slot),
		.found_data (found_data)
	);

`ifndef ASSERT_OFF
	// Never overwrite a response that the receiver has not yet taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("response register overwritten");

	// Table writes only on the back of a valid slot read
	a_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_claim || cmd.wr_tomb) |-> sts.ev_vld)
		else $error("table write without slot read");

	// One request at a time: no acceptance directly after an acceptance
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("back-to-back request acceptance");

	// Misses and full-table responses carry slot 0 and zero data
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != lphtu_pkg::ST_OK) |-> (slot == '0 && found_data == '0))
		else $error("non-zero payload on failed request");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for linear_probe_hash_table_unit: a directed table, then random traffic.
// Depends on lphtu_pkg and the unit's RTL; every response is predicted by a slot model kept here.
`timescale 1ns / 100ps

module tb;
	import lphtu_pkg::*;

	// Operation code the unit must treat as a no-op miss
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 9;
	// Long receiver hold-off: starts once this many requests are in, lasts this long
	localparam int HOLD_AT       = 60;
	localparam int HOLD_CYCLES   = 300;
	// Window of accepted requests in which neither side idles
	localparam int CALM_FROM     = 300;
	localparam int CALM_TO       = 380;
	// Settle time after the final drain, longer than the slowest request, for stray responses
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int RUN_LIMIT_NS  = 3_000_000;

	localparam logic [KEY_W-1:0]  KEY_MAX  = {KEY_W{1'b1}};
	localparam logic [DATA_W-1:0] DATA_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] DATA_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
		logic [DATA_W-1:0] found_data;
	} response_t;

	// One directed row; 'fixed' rows carry a hand-written response
	typedef struct packed {
		logic [FUNC_W-1:0] op;
		logic [KEY_W-1:0]  k;
		logic [DATA_W-1:0] d;
		bit                fixed;
		response_t         res;
	} plan_row_t;

	// Bench-side view of the ports; every input starts at a known value
	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     in_valid   = 1'b0;
	logic                     in_ready;
	logic [FUNC_W-1:0]        func       = '0;
	logic [KEY_W-1:0]         key        = '0;
	logic signed [DATA_W-1:0] data       = '0;
	logic                     out_valid;
	logic                     out_ready  = 1'b0;
	logic [STAT_W-1:0]        status;
	logic [SLOT_W-1:0]        slot;
	logic signed [DATA_W-1:0] found_data;

	// Slot model: marks, keys and values as the unit should hold them
	mark_t             tbl_mark [TABLE_SIZE];
	logic [KEY_W-1:0]  tbl_key  [TABLE_SIZE];
	logic [DATA_W-1:0] tbl_value[TABLE_SIZE];

	response_t awaited_responses[$];
	plan_row_t directed_plan[$];
	logic [KEY_W-IDX_W-1:0] cluster_hi[4];

	int accepted_count = 0;
	int mismatch_count = 0;
	int op_tally[4];
	int status_tally[4];

	linear_probe_hash_table_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.key        (key),
		.data       (data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot       (slot),
		.found_data (found_data)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Walk the table from the home slot exactly as the unit should, and update
	// the slot model for inserts and deletes. Search and delete stop at an
	// empty slot and pass over tombstones; insert takes the first slot that is
	// not in use. Every walk gives up after one full lap of the table.
	function automatic response_t probe_table(input logic [FUNC_W-1:0] op,
			input logic [KEY_W-1:0] k, input logic [DATA_W-1:0] d);
		response_t        r;
		logic [IDX_W-1:0] p;
		bit               done;
		int               i;
		r.status     = ST_MISS;
		r.slot       = '0;
		r.found_data = '0;
		done         = 1'b0;
		if (op == FN_SEARCH || op == FN_DELETE) begin
			for (i = 0; i < TABLE_SIZE && !done; i++) begin
				p = k[IDX_W-1:0] + IDX_W'(i);
				if (tbl_mark[p] == MK_EMPTY) begin
					done = 1'b1;
				end else if (tbl_mark[p] == MK_USED && tbl_key[p] == k) begin
					done         = 1'b1;
					r.status     = ST_OK;
					r.slot       = p;
					r.found_data = tbl_value[p];
					if (op == FN_DELETE)
						tbl_mark[p] = MK_TOMB;
				end
			end
		end else if (op == FN_INSERT) begin
			r.status = ST_FULL;
			for (i = 0; i < TABLE_SIZE && !done; i++) begin
				p = k[IDX_W-1:0] + IDX_W'(i);
				if (tbl_mark[p] != MK_USED) begin
					done         = 1'b1;
					tbl_mark[p]  = MK_USED;
					tbl_key[p]   = k;
					tbl_value[p] = d;
					r.status     = ST_OK;
					r.slot       = p;
				end
			end
		end
		// the unused code changes nothing and reports a miss
		return r;
	endfunction

	function automatic bit calm_stretch();
		return accepted_count >= CALM_FROM && accepted_count < CALM_TO;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] MISMATCH: %s", $time, what);
	endtask

	task automatic add_row(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] k,
			input logic [DATA_W-1:0] d, input bit fixed, input logic [STAT_W-1:0] st,
			input logic [SLOT_W-1:0] sl, input logic [DATA_W-1:0] fd);
		plan_row_t row;
		row.op             = op;
		row.k              = k;
		row.d              = d;
		row.fixed          = fixed;
		row.res.status     = st;
		row.res.slot       = sl;
		row.res.found_data = fd;
		directed_plan.push_back(row);
	endtask

	// Offer one request and hold it until accepted. An idle gap, when taken,
	// drops valid first; otherwise valid stays high into the next request.
	task automatic send_request(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] k,
			input logic [DATA_W-1:0] d, input bit fixed, input response_t fixed_res);
		response_t predicted;
		if (!calm_stretch() && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= op;
		key      <= k;
		data     <= d;
		do @(posedge clk); while (!in_ready);
		// the model always advances, so the slot state stays right after fixed rows
		predicted = probe_table(op, k, d);
		awaited_responses.push_back(fixed ? fixed_res : predicted);
		accepted_count++;
		op_tally[op]++;
	endtask

	// Pause the sender until every outstanding response has been taken, or DRAIN_LIMIT runs out
	task automatic drain_responses();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (awaited_responses.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
	endtask

	// Keys that crowd a dozen home slots around the wrap point, sharing a
	// few upper patterns so that collisions and equal home slots are common.
	function automatic logic [KEY_W-1:0] cluster_key();
		logic [IDX_W-1:0] low;
		low = IDX_W'($urandom_range(0, 11) + 29);
		return {cluster_hi[$urandom_range(0, 3)], low};
	endfunction

	function automatic logic [DATA_W-1:0] pick_data();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return DATA_MAX;
		else if (r == 1)
			return DATA_MIN;
		return $urandom;
	endfunction

	// Mixed traffic on the crowded keys, with a little noise: unused codes and
	// requests on keys drawn from the whole range.
	task automatic churn_requests(input int count);
		response_t none;
		int        r;
		none = '0;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 35)
				send_request(FN_INSERT, cluster_key(), pick_data(), 1'b0, none);
			else if (r < 65)
				send_request(FN_SEARCH, cluster_key(), $urandom, 1'b0, none);
			else if (r < 93)
				send_request(FN_DELETE, cluster_key(), $urandom, 1'b0, none);
			else if (r < 97)
				send_request(FN_UNUSED, KEY_W'($urandom), $urandom, 1'b0, none);
			else
				send_request(FUNC_W'($urandom_range(0, 2)), KEY_W'($urandom), pick_data(),
					1'b0, none);
		end
	endtask

	// Check each response taken against the oldest prediction
	always @(posedge clk) begin : response_check
		response_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_responses.size() == 0) begin
				report_mismatch($sformatf("unexpected response: status %0d slot %0d data %0d",
					status, slot, found_data));
			end else begin
				want = awaited_responses.pop_front();
				status_tally[want.status]++;
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
				if (slot !== want.slot)
					report_mismatch($sformatf("slot %0d, predicted %0d", slot, want.slot));
				if (found_data !== want.found_data)
					report_mismatch($sformatf("found_data %0h, predicted %0h",
						found_data, want.found_data));
			end
		end
	end

	// Receiver: random back-pressure, one long hold-off early in the random
	// part so the output register fills and the unit stalls its input, and no
	// back-pressure at all inside the calm window.
	initial begin : receiver
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && accepted_count >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm_stretch() || ($urandom_range(99) >= 8);
			end
		end
	end

	initial begin : stimulus
		logic [KEY_W-1:0] filled_keys[$];
		plan_row_t        row;
		response_t        none;
		int               i;

		none = '0;
		for (i = 0; i < TABLE_SIZE; i++) begin
			tbl_mark[i]  = MK_EMPTY;
			tbl_key[i]   = '0;
			tbl_value[i] = '0;
		end
		for (i = 0; i < 4; i++) begin
			cluster_hi[i]   = (KEY_W - IDX_W)'($urandom);
			op_tally[i]     = 0;
			status_tally[i] = 0;
		end

		// Directed part. Fixed rows: misses on the empty table, the unused
		// code, inserts into free home slots at both ends of the key range,
		// and hits on them. The rest exercise collisions, wrap-round, tombstone
		// skipping and reuse, duplicate keys and deletes, and use the model.
		add_row(FN_SEARCH, 31'd5,   32'd0,        1'b1, ST_MISS, 5'd0,  32'd0);
		add_row(FN_DELETE, KEY_MAX, 32'd0,        1'b1, ST_MISS, 5'd0,  32'd0);
		add_row(FN_UNUSED, 31'd7,   32'hFFFF_FFFF, 1'b1, ST_MISS, 5'd0,  32'd0);
		add_row(FN_INSERT, 31'd0,   DATA_MAX,     1'b1, ST_OK,   5'd0,  32'd0);
		add_row(FN_INSERT, KEY_MAX, DATA_MIN,     1'b1, ST_OK,   5'd31, 32'd0);
		add_row(FN_INSERT, 31'd32,  32'd1,        1'b0, ST_OK,   5'd0,  32'd0);
		add_row(FN_INSERT, 31'd63,  32'd2,        1'b0, ST_OK,   5'd0,  32'd0);
		add_row(FN_SEARCH, KEY_MAX, 32'd0,        1'b1, ST_OK,   5'd31, DATA_MIN);
		add_row(FN_SEARCH, 31'd0,   32'd0,        1'b1, ST_OK,   5'd0,  DATA_MAX);
		add_row(FN_SEARCH, 31'd63,  32'd0,        1'b0, ST_OK,   5'd0,  32'd0);
		add_row(FN_DELETE, 31'd32,  32'd0,        1'b0, ST_OK,   5'd0,  32'd0);
		add_row(FN_SEARCH, 31'd63,  32'd0,        1'b0, ST_OK,   5'd0,  32'd0);
		add_row(FN_SEARCH, 31'd32,  32'd0,        1'b0, ST_OK,   5'd0,  32'd0);
		add_row(FN_INSERT, 31'd64,  32'hFFFF_FFFB, 1'b0, ST_OK,   5'd0,  32'd0);
		add_row(FN_INSERT, 31'd0,   32'd123,      1'b0, ST_OK,   5'd0,  32'd0);
		add_row(FN_DELETE, 31'd0,   32'd0,        1'b0, ST_OK,   5'd0,  32'd0);
		add_row(FN_SEARCH, 31'd0,   32'd0,        1'b0, ST_OK,   5'd0,  32'd0);
		add_row(FN_UNUSED, 31'd0,   32'd0,        1'b1, ST_MISS, 5'd0,  32'd0);
		add_row(FN_SEARCH, 31'd0,   32'd0,        1'b0, ST_OK,   5'd0,  32'd0);
		add_row(FN_DELETE, KEY_MAX, 32'd0,        1'b0, ST_OK,   5'd0,  32'd0);
		add_row(FN_DELETE, KEY_MAX, 32'd0,        1'b0, ST_OK,   5'd0,  32'd0);
		add_row(FN_SEARCH, 31'd1,   32'hFFFF_FFFF, 1'b0, ST_OK,   5'd0,  32'd0);
		add_row(FN_DELETE, 31'd63,  32'd0,        1'b0, ST_OK,   5'd0,  32'd0);
		add_row(FN_DELETE, 31'd64,  32'd0,        1'b0, ST_OK,   5'd0,  32'd0);
		add_row(FN_INSERT, KEY_MAX, 32'd0,        1'b0, ST_OK,   5'd0,  32'd0);

		// Hold reset for the first cycles, then release it once for good
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[j]) begin
			row = directed_plan[j];
			send_request(row.op, row.k, row.d, row.fixed, row.res);
		end
		drain_responses();

		// Churn while empty slots still exist, so misses stop at an empty slot
		churn_requests(200);
		drain_responses();

		// Fill the table with keys from the whole range until inserts report
		// full, look keys up on a table with no empty slot (misses then walk a
		// full lap), and delete a batch to leave tombstones behind.
		repeat (40) begin
			filled_keys.push_back(KEY_W'($urandom));
			send_request(FN_INSERT, filled_keys[filled_keys.size() - 1], pick_data(),
				1'b0, none);
		end
		repeat (16)
			send_request(FN_SEARCH, filled_keys[$urandom_range(0, filled_keys.size() - 1)],
				$urandom, 1'b0, none);
		repeat (10)
			send_request(FN_SEARCH, KEY_W'($urandom), $urandom, 1'b0, none);
		for (i = 0; i < 24; i++)
			send_request(FN_DELETE, filled_keys[i], $urandom, 1'b0, none);
		drain_responses();

		// Churn again on a table laden with tombstones
		churn_requests(140);
		drain_responses();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (awaited_responses.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived",
				awaited_responses.size()));

		$display("Covered %0d requests: %0d search, %0d insert, %0d delete, %0d unused code.",
			accepted_count, op_tally[FN_SEARCH], op_tally[FN_INSERT], op_tally[FN_DELETE],
			op_tally[FN_UNUSED]);
		$display("Responses checked: %0d ok, %0d miss, %0d table full; %0d mismatches.",
			status_tally[ST_OK], status_tally[ST_MISS], status_tally[ST_FULL],
			mismatch_count);
		if (mismatch_count == 0)
			$display("linear_probe_hash_table_unit test passed");
		else
			$display("linear_probe_hash_table_unit test failed");
		$finish;
	end

	// Stop a hung run well after the slowest correct one would have ended
	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("linear_probe_hash_table_unit test failed");
		$finish;
	end

endmodule

// ===== linear_probe_hash_table_unit.f =====
hw/rtl/lphtu_pkg.sv
hw/rtl/lphtu_dp.sv
hw/rtl/lphtu_ctrl.sv
hw/rtl/linear_probe_hash_table_unit.sv
tb/sv/tb.sv
